// ----- hw/rtl/spreadsheet_range_reference_parser_macros.svh -----
`ifndef SPREADSHEET_RANGE_REFERENCE_PARSER_MACROS_SVH
`define SPREADSHEET_RANGE_REFERENCE_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range parser check failed");

// next-cycle implication, disabled in reset
`define SRRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range parser check failed");

`endif

// ----- hw/rtl/srrp_pkg.sv -----
package srrp_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAC_BITS    = VALUE_BITS + 5;
    localparam int BOUND_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MAC_BITS-1:0] VALUE_LIMIT = MAC_BITS'((64'd1 << VALUE_BITS) - 64'd1);

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;

    typedef struct packed {
        logic       letter;
        logic       digit;
        logic       colon;
        logic [4:0] weight;
        logic       last;
    } srrp_tok_t;

endpackage

// ----- hw/rtl/srrp_text_if.sv -----
interface srrp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
    modport monitor (input valid, input char_code, input last_char, input ready);
endinterface

// ----- hw/rtl/srrp_bounds_if.sv -----
interface srrp_bounds_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] col_first;
    logic signed [31:0] col_last;
    logic signed [31:0] row_first;
    logic signed [31:0] row_last;

    modport source (
        output valid, output ok, output col_first, output col_last,
        output row_first, output row_last, input ready
    );
    modport sink (
        input valid, input ok, input col_first, input col_last,
        input row_first, input row_last, output ready
    );
    modport monitor (
        input valid, input ok, input col_first, input col_last,
        input row_first, input row_last, input ready
    );
endinterface

// ----- hw/rtl/srrp_front.sv -----
module srrp_front
    import srrp_pkg::*;
(
    srrp_text_if.sink  text,
    output srrp_tok_t  tok,
    output logic       tok_valid,
    input  logic       tok_ready
);

    logic [7:0] c;
    logic       is_upper;
    logic       is_lower;

    assign c        = text.char_code;
    assign is_upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    assign is_lower = (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);

    always_comb
    begin
        tok.letter = is_upper || is_lower;
        tok.digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        tok.colon  = (c == CHAR_COLON);
        tok.last   = text.last_char;
        // letters weigh 1..26 from their low bits, digits 0..9
        if (is_upper || is_lower)
        begin
            tok.weight = c[4:0];
        end
        else
        begin
            tok.weight = {1'b0, c[3:0]};
        end
    end

    assign tok_valid  = text.valid;
    assign text.ready = tok_ready;

endmodule

// ----- hw/rtl/srrp_queue.sv -----
module srrp_queue
    import srrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  srrp_tok_t push_tok,
    input  logic      push_valid,
    output logic      push_ready,
    output srrp_tok_t pop_tok,
    output logic      pop_valid,
    input  logic      pop_ready
);

    srrp_tok_t              mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/srrp_back.sv -----
module srrp_back
    import srrp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  srrp_tok_t      tok,
    input  logic           tok_valid,
    output logic           tok_ready,
    srrp_bounds_if.source  bounds
);

    typedef enum logic [2:0] {
        PH_START,
        PH_COL1,
        PH_ROW1,
        PH_COLON,
        PH_COL2,
        PH_ROW2
    } phase_t;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [VALUE_BITS-1:0]   fc_reg;
    logic [VALUE_BITS-1:0]   fc_next;
    logic [VALUE_BITS-1:0]   fr_reg;
    logic [VALUE_BITS-1:0]   fr_next;
    logic [VALUE_BITS-1:0]   sc_reg;
    logic [VALUE_BITS-1:0]   sc_next;
    logic [VALUE_BITS-1:0]   sr_reg;
    logic [VALUE_BITS-1:0]   sr_next;
    logic                    scg_reg;
    logic                    scg_next;
    logic                    srg_reg;
    logic                    srg_next;
    logic                    err_reg;
    logic                    err_next;

    logic                    res_valid_reg;
    logic                    res_ok_reg;
    logic [VALUE_BITS-1:0]   res_fc_reg;
    logic [VALUE_BITS-1:0]   res_fr_reg;
    logic [VALUE_BITS-1:0]   res_sc_reg;
    logic [VALUE_BITS-1:0]   res_sr_reg;
    logic                    res_scg_reg;
    logic                    res_srg_reg;

    logic                    second_part;
    logic [VALUE_BITS-1:0]   acc;
    logic [MAC_BITS-1:0]     acc_wide;
    logic [MAC_BITS-1:0]     mac;
    logic                    ovf;
    logic [VALUE_BITS-1:0]   mac_val;
    logic                    take;
    logic                    ok_next;
    logic [BOUND_BITS-1:0]   c0;
    logic [BOUND_BITS-1:0]   c1;
    logic [BOUND_BITS-1:0]   r0;
    logic [BOUND_BITS-1:0]   r1;

    function automatic logic [BOUND_BITS-1:0] to_bound(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v) - 64'd1;
        return w[BOUND_BITS-1:0];
    endfunction

    assign tok_ready = !tok.last || !res_valid_reg || bounds.ready;
    assign take      = tok_valid && tok_ready;

    assign second_part = (phase_reg == PH_COLON) || (phase_reg == PH_COL2)
                         || (phase_reg == PH_ROW2);

    always_comb
    begin
        if (second_part)
        begin
            acc = tok.digit ? sr_reg : sc_reg;
        end
        else
        begin
            acc = tok.digit ? fr_reg : fc_reg;
        end
        acc_wide = MAC_BITS'(acc);
        // times 26 for letters, times 10 for digits
        if (tok.letter)
        begin
            mac = (acc_wide << 4) + (acc_wide << 3) + (acc_wide << 1) + MAC_BITS'(tok.weight);
        end
        else
        begin
            mac = (acc_wide << 3) + (acc_wide << 1) + MAC_BITS'(tok.weight);
        end
        ovf     = (tok.letter || tok.digit) && (mac > VALUE_LIMIT);
        mac_val = mac[VALUE_BITS-1:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        fc_next    = fc_reg;
        fr_next    = fr_reg;
        sc_next    = sc_reg;
        sr_next    = sr_reg;
        scg_next   = scg_reg;
        srg_next   = srg_reg;
        err_next   = err_reg || ovf;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_START, PH_COL1:
                begin
                    if (tok.letter)
                    begin
                        if (!ovf) fc_next = mac_val;
                        phase_next = PH_COL1;
                    end
                    else if (tok.digit)
                    begin
                        if (!ovf) fr_next = mac_val;
                        phase_next = PH_ROW1;
                    end
                    else if (tok.colon && (phase_reg == PH_COL1))
                    begin
                        phase_next = PH_COLON;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_ROW1:
                begin
                    if (tok.digit)
                    begin
                        if (!ovf) fr_next = mac_val;
                    end
                    else if (tok.colon)
                    begin
                        err_next   = (fr_reg == '0);
                        phase_next = PH_COLON;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_COLON, PH_COL2:
                begin
                    if (tok.letter)
                    begin
                        if (!ovf) sc_next = mac_val;
                        scg_next   = 1'b1;
                        phase_next = PH_COL2;
                    end
                    else if (tok.digit)
                    begin
                        if (!ovf) sr_next = mac_val;
                        srg_next   = 1'b1;
                        phase_next = PH_ROW2;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_ROW2:
                begin
                    if (tok.digit)
                    begin
                        if (!ovf) sr_next = mac_val;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end
        else
        begin
            err_next = 1'b1;
        end
        ok_next = !err_next && !((phase_next == PH_ROW1) && (fr_next == '0))
                  && !(srg_next && (sr_next == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            fc_reg        <= '0;
            fr_reg        <= '0;
            sc_reg        <= '0;
            sr_reg        <= '0;
            scg_reg       <= 1'b0;
            srg_reg       <= 1'b0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_fc_reg    <= '0;
            res_fr_reg    <= '0;
            res_sc_reg    <= '0;
            res_sr_reg    <= '0;
            res_scg_reg   <= 1'b0;
            res_srg_reg   <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && bounds.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (tok.last)
                begin
                    // latch the finished reference, then start afresh
                    res_valid_reg <= 1'b1;
                    res_ok_reg    <= ok_next;
                    res_fc_reg    <= fc_next;
                    res_fr_reg    <= fr_next;
                    res_sc_reg    <= sc_next;
                    res_sr_reg    <= sr_next;
                    res_scg_reg   <= scg_next;
                    res_srg_reg   <= srg_next;
                    phase_reg     <= PH_START;
                    fc_reg        <= '0;
                    fr_reg        <= '0;
                    sc_reg        <= '0;
                    sr_reg        <= '0;
                    scg_reg       <= 1'b0;
                    srg_reg       <= 1'b0;
                    err_reg       <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    fc_reg    <= fc_next;
                    fr_reg    <= fr_next;
                    sc_reg    <= sc_next;
                    sr_reg    <= sr_next;
                    scg_reg   <= scg_next;
                    srg_reg   <= srg_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_comb
    begin
        c0 = to_bound(res_fc_reg);
        r0 = to_bound(res_fr_reg);
        c1 = res_scg_reg ? to_bound(res_sc_reg) : c0;
        r1 = res_srg_reg ? to_bound(res_sr_reg) : r0;
    end

    assign bounds.valid     = res_valid_reg;
    assign bounds.ok        = res_ok_reg;
    assign bounds.col_first = res_ok_reg ? signed'(c0) : '0;
    assign bounds.col_last  = res_ok_reg ? signed'(c1) : '0;
    assign bounds.row_first = res_ok_reg ? signed'(r0) : '0;
    assign bounds.row_last  = res_ok_reg ? signed'(r1) : '0;

endmodule

// ----- hw/rtl/spreadsheet_range_reference_parser.sv -----
// channel  role    modport  payload
// text     input   sink     char_code[7:0], last_char
// bounds   output  source   ok, col_first, col_last, row_first, row_last (32-bit signed)
//
// One byte a cycle while text.ready holds; a last byte is queued, then latched as a result.
// The back end does one multiply-accumulate per byte; a two-word queue sits before it.
// text.ready drops only while the queue is full, which the back end causes only when
// a last byte waits behind an untaken result.
// rst_n clears the parse state, the queue and the result register asynchronously.
module spreadsheet_range_reference_parser
    import srrp_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    srrp_text_if.sink     text,
    srrp_bounds_if.source bounds
);

    srrp_tok_t front_tok;
    logic      front_valid;
    logic      front_ready;
    srrp_tok_t back_tok;
    logic      back_valid;
    logic      back_ready;

    srrp_front u_front (
        .text      (text),
        .tok       (front_tok),
        .tok_valid (front_valid),
        .tok_ready (front_ready)
    );

    srrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_tok   (front_tok),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_tok    (back_tok),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    srrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (back_tok),
        .tok_valid (back_valid),
        .tok_ready (back_ready),
        .bounds    (bounds)
    );

endmodule

// ----- hw/rtl/srrp_checker.sv -----
`include "spreadsheet_range_reference_parser_macros.svh"

module srrp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input logic               ok,
    input logic signed [31:0] col_first,
    input logic signed [31:0] col_last,
    input logic signed [31:0] row_first,
    input logic signed [31:0] row_last
);

    logic [128:0] bounds_word;
    logic         stalled;
    logic         failed;
    logic         passed;
    logic         all_zero;
    logic         first_in_range;
    logic         last_in_range;

    assign bounds_word    = {ok, col_first, col_last, row_first, row_last};
    assign stalled        = valid && !ready;
    assign failed         = valid && !ok;
    assign passed         = valid && ok;
    assign all_zero       = (col_first == 32'sd0) && (col_last == 32'sd0)
                            && (row_first == 32'sd0) && (row_last == 32'sd0);
    assign first_in_range = (!col_first[31] || (col_first == -32'sd1))
                            && (!row_first[31] || (row_first == -32'sd1))
                            && (col_first != 32'sh7fffffff)
                            && (row_first != 32'sh7fffffff);
    assign last_in_range  = (!col_last[31] || (col_last == -32'sd1))
                            && (!row_last[31] || (row_last == -32'sd1));

    `SRRP_ASSERT_NEXT(a_hold_stalled, clk, rst_n, stalled, valid && $stable(bounds_word))

    `SRRP_ASSERT_SAME(a_error_zeroes, clk, rst_n, failed, all_zero)

    `SRRP_ASSERT_SAME(a_bounds_range, clk, rst_n, passed, first_in_range)

    `SRRP_ASSERT_SAME(a_last_range, clk, rst_n, passed, last_in_range)

endmodule

bind spreadsheet_range_reference_parser srrp_checker u_srrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (bounds.valid),
    .ready     (bounds.ready),
    .ok        (bounds.ok),
    .col_first (bounds.col_first),
    .col_last  (bounds.col_last),
    .row_first (bounds.row_first),
    .row_last  (bounds.row_last)
);

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] col_first;
        logic signed [31:0] col_last;
        logic signed [31:0] row_first;
        logic signed [31:0] row_last;
    } cell_bounds_t;

    typedef struct packed {
        logic [7:0]   code;
        logic         last;
        logic         typed;
        cell_bounds_t want;
    } text_row_t;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_COL_A,
        PARSE_ROW_A,
        PARSE_SEP,
        PARSE_COL_B,
        PARSE_ROW_B
    } parse_phase_e;

    localparam longint unsigned VALUE_MAX    = 64'h7FFF_FFFF;
    localparam int              RANDOM_BYTES = 1100;
    localparam int              TAIL_BYTES   = 150;
    localparam int              HOLD_AFTER   = 300;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              QUIET_LIMIT  = 2000;
    localparam int              PRINT_CAP    = 100;
    localparam cell_bounds_t    REJECTED     = '0;

    logic clk;
    logic rst_n;

    srrp_text_if   text ();
    srrp_bounds_if bounds ();

    spreadsheet_range_reference_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .bounds (bounds)
    );

    parse_phase_e    parse_phase;
    longint unsigned col_a;
    longint unsigned row_a;
    longint unsigned col_b;
    longint unsigned row_b;
    bit              col_b_seen;
    bit              row_b_seen;
    bit              parse_bad;

    cell_bounds_t    expected_bounds[$];
    logic [7:0]      reference_bytes[$];
    text_row_t       directed_rows[24];
    int              mismatches;
    int              random_bytes_taken;
    bit              steady_tail;
    bit              gappy;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_parser();
        parse_phase = PARSE_IDLE;
        col_a = 0;
        row_a = 0;
        col_b = 0;
        row_b = 0;
        col_b_seen = 1'b0;
        row_b_seen = 1'b0;
        parse_bad = 1'b0;
    endfunction

    function automatic longint unsigned fold(input longint unsigned acc,
                                             input longint unsigned base,
                                             input longint unsigned add);
        if (acc > (VALUE_MAX - add) / base)
        begin
            parse_bad = 1'b1;
            return acc;
        end
        return acc * base + add;
    endfunction

    function automatic void parse_byte(input logic [7:0] code, input logic last,
                                       output bit emits, output cell_bounds_t res);
        bit              is_letter;
        bit              is_digit;
        bit              is_colon;
        bit              ok;
        logic [7:0]      weight;
        longint unsigned digit;
        is_letter = (code >= "A" && code <= "Z") || (code >= "a" && code <= "z");
        is_digit  = code >= "0" && code <= "9";
        is_colon  = code == ":";
        weight    = (code >= "a") ? code - "a" : code - "A";
        digit     = longint'(code - "0");
        emits     = 1'b0;
        res       = REJECTED;
        if (!parse_bad)
        begin
            case (parse_phase)
                PARSE_IDLE, PARSE_COL_A:
                begin
                    if (is_letter)
                    begin
                        col_a = fold(col_a, 26, longint'(weight) + 1);
                        parse_phase = PARSE_COL_A;
                    end
                    else if (is_digit)
                    begin
                        row_a = fold(row_a, 10, digit);
                        parse_phase = PARSE_ROW_A;
                    end
                    else if (is_colon && parse_phase == PARSE_COL_A)
                        parse_phase = PARSE_SEP;
                    else
                        parse_bad = 1'b1;
                end
                PARSE_ROW_A:
                begin
                    if (is_digit)
                        row_a = fold(row_a, 10, digit);
                    else if (is_colon)
                    begin
                        if (row_a == 0)
                            parse_bad = 1'b1;
                        parse_phase = PARSE_SEP;
                    end
                    else
                        parse_bad = 1'b1;
                end
                PARSE_SEP, PARSE_COL_B:
                begin
                    if (is_letter)
                    begin
                        col_b = fold(col_b, 26, longint'(weight) + 1);
                        col_b_seen = 1'b1;
                        parse_phase = PARSE_COL_B;
                    end
                    else if (is_digit)
                    begin
                        row_b = fold(row_b, 10, digit);
                        row_b_seen = 1'b1;
                        parse_phase = PARSE_ROW_B;
                    end
                    else
                        parse_bad = 1'b1;
                end
                PARSE_ROW_B:
                begin
                    if (is_digit)
                        row_b = fold(row_b, 10, digit);
                    else
                        parse_bad = 1'b1;
                end
                default:
                    parse_bad = 1'b1;
            endcase
        end
        if (!last)
            return;
        emits = 1'b1;
        ok = !parse_bad && !(parse_phase == PARSE_ROW_A && row_a == 0)
             && !(row_b_seen && row_b == 0);
        if (ok)
        begin
            res.ok        = 1'b1;
            res.col_first = 32'(col_a - 1);
            res.row_first = 32'(row_a - 1);
            res.col_last  = col_b_seen ? 32'(col_b - 1) : res.col_first;
            res.row_last  = row_b_seen ? 32'(row_b - 1) : res.row_first;
        end
        clear_parser();
    endfunction

    function automatic longint unsigned pick_value(input bit is_row);
        case ($urandom_range(0, 9))
            6: return longint'($urandom_range(1, 32'(VALUE_MAX)));
            7: return VALUE_MAX - $urandom_range(0, 30);
            8: return VALUE_MAX + $urandom_range(1, 30);
            9: return is_row ? 0 : longint'($urandom) + VALUE_MAX + 1;
            default: return is_row ? $urandom_range(1, 9999) : $urandom_range(1, 800);
        endcase
    endfunction

    function automatic void append_column(input longint unsigned v);
        logic [7:0] letters[$];
        logic [7:0] d;
        while (v > 0)
        begin
            d = 8'((v - 1) % 26);
            letters.push_front(($urandom_range(0, 1) ? "a" : "A") + d);
            v = (v - 1) / 26;
        end
        foreach (letters[i])
            reference_bytes.push_back(letters[i]);
    endfunction

    function automatic void append_row(input longint unsigned v);
        logic [7:0] digits[$];
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) reference_bytes.push_back("0");
        do
        begin
            digits.push_front("0" + 8'(v % 10));
            v = v / 10;
        end
        while (v > 0);
        foreach (digits[i])
            reference_bytes.push_back(digits[i]);
    endfunction

    // mostly well-formed references, some with a stray byte, some pure noise
    function automatic void build_reference();
        int kind;
        bit has_col;
        bit has_row;
        reference_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 6))
                reference_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        has_col = $urandom_range(0, 4) != 0;
        has_row = !has_col || $urandom_range(0, 4) != 0;
        if (has_col)
            append_column(pick_value(1'b0));
        if (has_row)
            append_row(pick_value(1'b1));
        if ($urandom_range(0, 2) != 0)
        begin
            reference_bytes.push_back(":");
            if ($urandom_range(0, 4) != 0)
                append_column(pick_value(1'b0));
            if ($urandom_range(0, 4) != 0)
                append_row(pick_value(1'b1));
        end
        if (kind == 8)
            reference_bytes.insert($urandom_range(0, reference_bytes.size()),
                                   8'($urandom_range(0, 255)));
    endfunction

    task automatic push_byte(input logic [7:0] code, input logic last,
                             input logic typed, input cell_bounds_t want);
        bit           emits;
        cell_bounds_t res;
        if (gappy && !steady_tail && $urandom_range(0, 3) == 0)
        begin
            text.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text.valid     <= 1'b1;
        text.char_code <= code;
        text.last_char <= last;
        do
            @(posedge clk);
        while (!text.ready);
        parse_byte(code, last, emits, res);
        if (emits)
            expected_bounds.push_back(typed ? want : res);
    endtask

    initial
    begin
        text.valid     <= 1'b0;
        text.char_code <= 8'h00;
        text.last_char <= 1'b0;
        rst_n          <= 1'b0;
        mismatches          = 0;
        random_bytes_taken  = 0;
        steady_tail         = 1'b0;
        gappy               = 1'b0;
        clear_parser();
        directed_rows = '{
            '{":",   1'b1, 1'b1, REJECTED},
            '{"A",   1'b0, 1'b0, REJECTED},
            '{"1",   1'b0, 1'b0, REJECTED},
            '{":",   1'b1, 1'b1, '{1'b1, 0, 0, 0, 0}},
            '{"0",   1'b1, 1'b1, REJECTED},
            '{"z",   1'b0, 1'b0, REJECTED},
            '{"Z",   1'b1, 1'b1, '{1'b1, 701, 701, -1, -1}},
            '{8'h00, 1'b1, 1'b1, REJECTED},
            '{8'hFF, 1'b1, 1'b1, REJECTED},
            '{"1",   1'b0, 1'b0, REJECTED},
            '{"A",   1'b1, 1'b1, REJECTED},
            '{"A",   1'b0, 1'b0, REJECTED},
            '{":",   1'b0, 1'b0, REJECTED},
            '{":",   1'b1, 1'b1, REJECTED},
            '{"2",   1'b0, 1'b0, REJECTED},
            '{"1",   1'b0, 1'b0, REJECTED},
            '{"4",   1'b0, 1'b0, REJECTED},
            '{"7",   1'b0, 1'b0, REJECTED},
            '{"4",   1'b0, 1'b0, REJECTED},
            '{"8",   1'b0, 1'b0, REJECTED},
            '{"3",   1'b0, 1'b0, REJECTED},
            '{"6",   1'b0, 1'b0, REJECTED},
            '{"4",   1'b0, 1'b0, REJECTED},
            '{"8",   1'b1, 1'b1, REJECTED}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            push_byte(directed_rows[i].code, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        while (random_bytes_taken < RANDOM_BYTES)
        begin
            build_reference();
            gappy = $urandom_range(0, 1);
            foreach (reference_bytes[i])
            begin
                push_byte(reference_bytes[i], i == reference_bytes.size() - 1,
                          1'b0, REJECTED);
                random_bytes_taken++;
                steady_tail = random_bytes_taken >= RANDOM_BYTES - TAIL_BYTES;
            end
        end
        text.valid <= 1'b0;
        while (expected_bounds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("spreadsheet_range_reference_parser test passed");
        else
            $display("spreadsheet_range_reference_parser test failed");
        $finish;
    end

    initial
    begin
        int           stall_left;
        int           cycle_count;
        bit           held_off;
        bit           lazy;
        cell_bounds_t want;
        stall_left  = 0;
        cycle_count = 0;
        held_off    = 1'b0;
        lazy        = 1'b0;
        bounds.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (bounds.valid && bounds.ready)
            begin
                if (expected_bounds.size() == 0)
                    report_mismatch("result word with none expected");
                else
                begin
                    want = expected_bounds.pop_front();
                    if (bounds.ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", bounds.ok, want.ok));
                    if (bounds.col_first !== want.col_first)
                        report_mismatch($sformatf("col_first %0d, expected %0d",
                                                  bounds.col_first, want.col_first));
                    if (bounds.col_last !== want.col_last)
                        report_mismatch($sformatf("col_last %0d, expected %0d",
                                                  bounds.col_last, want.col_last));
                    if (bounds.row_first !== want.row_first)
                        report_mismatch($sformatf("row_first %0d, expected %0d",
                                                  bounds.row_first, want.row_first));
                    if (bounds.row_last !== want.row_last)
                        report_mismatch($sformatf("row_last %0d, expected %0d",
                                                  bounds.row_last, want.row_last));
                end
            end
            cycle_count++;
            if (cycle_count % 64 == 0)
                lazy = $urandom_range(0, 1);
            // hold off once for long enough that the input side backs up
            if (!held_off && random_bytes_taken >= HOLD_AFTER)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && lazy && !steady_tail && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                stall_left--;
                bounds.ready <= 1'b0;
            end
            else
                bounds.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((text.valid && text.ready) || (bounds.valid && bounds.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("spreadsheet_range_reference_parser test failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/srrp_pkg.sv
hw/rtl/srrp_text_if.sv
hw/rtl/srrp_bounds_if.sv
hw/rtl/srrp_front.sv
hw/rtl/srrp_queue.sv
hw/rtl/srrp_back.sv
hw/rtl/spreadsheet_range_reference_parser.sv
hw/rtl/srrp_checker.sv
tb/tb_top.sv
